[rtl/m2fr_pkg.sv]
`default_nettype none

package m2fr_pkg;

	// Frame delimiters
	localparam logic [7:0] SOF_CHAR = 8'h24;  // '$'
	localparam logic [7:0] VER_CHAR = 8'h58;  // 'X'

	// Header byte positions after the 'X'
	localparam logic [15:0] POS_ID_LO  = 16'd2;
	localparam logic [15:0] POS_ID_HI  = 16'd3;
	localparam logic [15:0] POS_LEN_LO = 16'd4;
	localparam logic [15:0] POS_LEN_HI = 16'd5;

	// Payload capture and minimum frame lengths
	localparam int          KEEP_BYTES    = 9;
	localparam logic [15:0] KEEP_LIMIT    = 16'(KEEP_BYTES);
	localparam logic [15:0] FLOW_MIN_LEN  = 16'd9;
	localparam logic [15:0] RANGE_MIN_LEN = 16'd5;

	// Configuration register map
	localparam int               CFG_IDX_W     = 4;
	localparam logic [CFG_IDX_W-1:0] REG_FLOW_ID  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_ID = CFG_IDX_W'(1);
	localparam logic [15:0]      FLOW_ID_RST   = 16'd7938;
	localparam logic [15:0]      RANGE_ID_RST  = 16'd7937;

	// Result kinds
	localparam logic KIND_FLOW  = 1'b0;
	localparam logic KIND_RANGE = 1'b1;

	// Flow conversion: q = round(mag * 44680448 / 390625)
	//   = 114 * mag + floor((mag * 149198 + 195312) / 390625)
	localparam logic [6:0]  CONV_INT_GAIN  = 7'd114;
	localparam logic [17:0] CONV_FRAC_GAIN = 18'd149198;
	localparam logic [17:0] CONV_ROUND     = 18'd195312;
	localparam logic [18:0] CONV_DIV       = 19'd390625;
	localparam logic [20:0] CONV_DIV2      = 21'd781250;
	// floor(2^50 / 390625), applied to the upper bits [42:18] of the numerator
	localparam logic [31:0] CONV_RECIP     = 32'd2882303761;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_GOT_SOF,
		PH_HEADER,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	// What travels with a frame event down the conversion pipeline
	typedef struct packed {
		logic        kind;
		logic [7:0]  quality;
		logic [31:0] range;
	} event_t;

	// Stage load enables for the conversion pipeline
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} adv_t;

endpackage

`default_nettype wire

[rtl/m2fr_flow_conv.sv]
`default_nettype none

// Tenths of deg/s (two's complement) to saturated Q16.16 rad/s, four stages.
module m2fr_flow_conv (
	input  wire logic          clk,
	input  wire m2fr_pkg::adv_t adv,
	input  wire logic [31:0]   raw,
	output logic [31:0]        rate
);

	logic [31:0] mag;
	logic        neg_c;
	logic [42:0] num_c;
	logic [31:0] base_c;

	logic        neg_s2, big_s2;
	logic [42:0] num_s2;
	logic [31:0] base_s2;

	logic [56:0] prod_c;

	logic        neg_s3, big_s3;
	logic [20:0] num_lo_s3;
	logic [31:0] base_s3;
	logic [24:0] est_s3;

	logic [43:0] estd_c;

	logic        neg_s4, big_s4;
	logic [20:0] rem_s4;
	logic [31:0] base_s4;
	logic [24:0] est_s4;

	logic [1:0]  corr_c;

	logic        neg_s5, big_s5;
	logic [32:0] q_s5;
	logic        sat;

	// Magnitude; only the low 25 bits can give an unsaturated result
	always_comb begin
		neg_c  = raw[31];
		mag    = neg_c ? (~raw + 32'd1) : raw;
		num_c  = 43'(mag[24:0]) * 43'(m2fr_pkg::CONV_FRAC_GAIN)
		       + 43'(m2fr_pkg::CONV_ROUND);
		base_c = 32'(mag[24:0]) * 32'(m2fr_pkg::CONV_INT_GAIN);
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			neg_s2  <= neg_c;
			big_s2  <= |mag[31:25];
			num_s2  <= num_c;
			base_s2 <= base_c;
		end
	end

	// Quotient estimate by reciprocal; low by at most two
	assign prod_c = 57'(num_s2[42:18]) * 57'(m2fr_pkg::CONV_RECIP);

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			neg_s3    <= neg_s2;
			big_s3    <= big_s2;
			num_lo_s3 <= num_s2[20:0];
			base_s3   <= base_s2;
			est_s3    <= prod_c[56:32];
		end
	end

	// Remainder is below three divisors, so 21 bits of it are exact
	assign estd_c = 44'(est_s3) * 44'(m2fr_pkg::CONV_DIV);

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			neg_s4  <= neg_s3;
			big_s4  <= big_s3;
			rem_s4  <= num_lo_s3 - estd_c[20:0];
			base_s4 <= base_s3;
			est_s4  <= est_s3;
		end
	end

	// Quotient correction and final magnitude
	always_comb begin
		corr_c = 2'(rem_s4 >= 21'(m2fr_pkg::CONV_DIV))
		       + 2'(rem_s4 >= m2fr_pkg::CONV_DIV2);
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			neg_s5 <= neg_s4;
			big_s5 <= big_s4;
			q_s5   <= 33'(base_s4) + 33'(est_s4) + 33'(corr_c);
		end
	end

	// Saturate at 2^31 in either direction, then apply the sign
	always_comb begin
		sat = big_s5 | q_s5[32] | q_s5[31];
		if (neg_s5) begin
			rate = sat ? 32'h8000_0000 : (32'd0 - q_s5[31:0]);
		end else begin
			rate = sat ? 32'h7FFF_FFFF : q_s5[31:0];
		end
	end

endmodule

`default_nettype wire

[rtl/msp2_flow_range_frame_parser.sv]
`default_nettype none

// Channel   Signals                                         Direction
// in        in_valid / in_ready / rx_byte                   byte stream in
// out       out_valid / out_ready / update_kind,            latest values out
//           flow_quality, flow_x_rad, flow_y_rad, range_mm
// cfg       cfg_valid / cfg_ready / cfg_index, cfg_data     register writes in
//
// One byte per cycle is taken while in_ready is high. The parser state updates
// in the accepting cycle; the checksum byte of a flow or range frame launches an
// event into a five-stage pipeline (event register plus four stages of the flow
// rate converter), whose result is then registered in the output register.
// Stages collapse bubbles, so in_ready drops only when every stage and the output
// register hold a transaction and out_ready is low. Reset clears the parser and
// the latest values to zero and the ids to their defaults; cfg_ready is always high.
module msp2_flow_range_frame_parser (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      rx_byte,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 update_kind,
	output logic [7:0]                           flow_quality,
	output logic signed [31:0]                   flow_x_rad,
	output logic signed [31:0]                   flow_y_rad,
	output logic signed [31:0]                   range_mm,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [m2fr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [15:0]                     cfg_data
);

	logic [15:0] flow_id_q, range_id_q;

	m2fr_pkg::phase_t phase_q, phase_n;
	logic [15:0] byte_pos_q, pos_n, pos_inc;
	logic [15:0] frame_id_q, id_n;
	logic [15:0] frame_len_q, len_n;
	logic [7:0]  pay_q [m2fr_pkg::KEEP_BYTES];
	logic        pay_we, ev_hit, ev_kind;
	logic        in_acc;

	m2fr_pkg::event_t ev_s1, ev_s2, ev_s3, ev_s4, ev_s5;
	logic [31:0] raw_x_s1, raw_y_s1;
	logic        v1_q, v2_q, v3_q, v4_q, v5_q;
	logic        ld2, ld3, ld4, ld5, ld_out;
	logic        free1, free2, free3, free4, free5;
	m2fr_pkg::adv_t adv;
	logic [31:0] conv_x, conv_y;

	logic        out_valid_q, kind_q;
	logic [7:0]  quality_q;
	logic [31:0] flow_x_q, flow_y_q, range_q;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_id_q  <= m2fr_pkg::FLOW_ID_RST;
			range_id_q <= m2fr_pkg::RANGE_ID_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				m2fr_pkg::REG_FLOW_ID:  flow_id_q  <= cfg_data;
				m2fr_pkg::REG_RANGE_ID: range_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage handshake: each stage loads when the next one is empty or moving
	assign ld_out = v5_q && (!out_valid_q || out_ready);
	assign free5  = !v5_q || ld_out;
	assign ld5    = v4_q && free5;
	assign free4  = !v4_q || ld5;
	assign ld4    = v3_q && free4;
	assign free3  = !v3_q || ld4;
	assign ld3    = v2_q && free3;
	assign free2  = !v2_q || ld3;
	assign ld2    = v1_q && free2;
	assign free1  = !v1_q || ld2;

	assign in_ready = free1;
	assign in_acc   = in_valid && in_ready;

	assign adv.s2 = ld2;
	assign adv.s3 = ld3;
	assign adv.s4 = ld4;
	assign adv.s5 = ld5;

	assign pos_inc = byte_pos_q + 16'd1;

	// Parser next phase
	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			m2fr_pkg::PH_HUNT: begin
				phase_n = (rx_byte == m2fr_pkg::SOF_CHAR) ? m2fr_pkg::PH_GOT_SOF
				                                          : m2fr_pkg::PH_HUNT;
			end
			m2fr_pkg::PH_GOT_SOF: begin
				if (rx_byte == m2fr_pkg::VER_CHAR) begin
					phase_n = m2fr_pkg::PH_HEADER;
				end else if (rx_byte != m2fr_pkg::SOF_CHAR) begin
					phase_n = m2fr_pkg::PH_HUNT;
				end
			end
			m2fr_pkg::PH_HEADER: begin
				if (byte_pos_q >= m2fr_pkg::POS_LEN_HI) begin
					phase_n = ({rx_byte, frame_len_q[7:0]} == 16'd0) ? m2fr_pkg::PH_CHECK
					                                                : m2fr_pkg::PH_PAYLOAD;
				end
			end
			m2fr_pkg::PH_PAYLOAD: begin
				if (pos_inc >= frame_len_q) begin
					phase_n = m2fr_pkg::PH_CHECK;
				end
			end
			m2fr_pkg::PH_CHECK: phase_n = m2fr_pkg::PH_HUNT;
			default:            phase_n = m2fr_pkg::PH_HUNT;
		endcase
	end

	// Parser counters, header fields, capture and frame decision
	always_comb begin
		pos_n   = byte_pos_q;
		id_n    = frame_id_q;
		len_n   = frame_len_q;
		pay_we  = 1'b0;
		ev_hit  = 1'b0;
		ev_kind = m2fr_pkg::KIND_FLOW;
		unique case (phase_q)
			m2fr_pkg::PH_GOT_SOF: begin
				if (rx_byte == m2fr_pkg::VER_CHAR) begin
					pos_n = '0;
					id_n  = '0;
					len_n = '0;
				end
			end
			m2fr_pkg::PH_HEADER: begin
				case (byte_pos_q)
					m2fr_pkg::POS_ID_LO:  id_n        = {8'h00, rx_byte};
					m2fr_pkg::POS_ID_HI:  id_n[15:8]  = rx_byte;
					m2fr_pkg::POS_LEN_LO: len_n       = {8'h00, rx_byte};
					m2fr_pkg::POS_LEN_HI: len_n[15:8] = rx_byte;
					default: ;
				endcase
				pos_n = (byte_pos_q >= m2fr_pkg::POS_LEN_HI) ? 16'd0 : pos_inc;
			end
			m2fr_pkg::PH_PAYLOAD: begin
				pay_we = byte_pos_q < m2fr_pkg::KEEP_LIMIT;
				pos_n  = (pos_inc >= frame_len_q) ? 16'd0 : pos_inc;
			end
			m2fr_pkg::PH_CHECK: begin
				pos_n = '0;
				// flow test takes priority when both ids match
				if (frame_id_q == flow_id_q && frame_len_q >= m2fr_pkg::FLOW_MIN_LEN) begin
					ev_hit  = 1'b1;
					ev_kind = m2fr_pkg::KIND_FLOW;
				end else if (frame_id_q == range_id_q &&
				             frame_len_q >= m2fr_pkg::RANGE_MIN_LEN) begin
					ev_hit  = 1'b1;
					ev_kind = m2fr_pkg::KIND_RANGE;
				end
			end
			default: ;
		endcase
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= m2fr_pkg::PH_HUNT;
			byte_pos_q  <= '0;
			frame_id_q  <= '0;
			frame_len_q <= '0;
		end else if (in_acc) begin
			phase_q     <= phase_n;
			byte_pos_q  <= pos_n;
			frame_id_q  <= id_n;
			frame_len_q <= len_n;
		end
	end

	// Payload capture, first bytes only
	always_ff @(posedge clk) begin
		if (in_acc && pay_we) begin
			pay_q[byte_pos_q[3:0]] <= rx_byte;
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			v1_q <= (in_acc && ev_hit) || (v1_q && !ld2);
			v2_q <= ld2 || (v2_q && !ld3);
			v3_q <= ld3 || (v3_q && !ld4);
			v4_q <= ld4 || (v4_q && !ld5);
			v5_q <= ld5 || (v5_q && !ld_out);
		end
	end

	// Event register and side-band pipeline
	always_ff @(posedge clk) begin
		if (in_acc && ev_hit) begin
			ev_s1.kind    <= ev_kind;
			ev_s1.quality <= pay_q[0];
			ev_s1.range   <= {pay_q[4], pay_q[3], pay_q[2], pay_q[1]};
			raw_x_s1      <= {pay_q[4], pay_q[3], pay_q[2], pay_q[1]};
			raw_y_s1      <= {pay_q[8], pay_q[7], pay_q[6], pay_q[5]};
		end
		if (ld2) ev_s2 <= ev_s1;
		if (ld3) ev_s3 <= ev_s2;
		if (ld4) ev_s4 <= ev_s3;
		if (ld5) ev_s5 <= ev_s4;
	end

	m2fr_flow_conv u_conv_x (
		.clk  (clk),
		.adv  (adv),
		.raw  (raw_x_s1),
		.rate (conv_x)
	);

	m2fr_flow_conv u_conv_y (
		.clk  (clk),
		.adv  (adv),
		.raw  (raw_y_s1),
		.rate (conv_y)
	);

	// Latest values double as the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			kind_q      <= m2fr_pkg::KIND_FLOW;
			quality_q   <= '0;
			flow_x_q    <= '0;
			flow_y_q    <= '0;
			range_q     <= '0;
		end else begin
			out_valid_q <= ld_out || (out_valid_q && !out_ready);
			if (ld_out) begin
				kind_q <= ev_s5.kind;
				if (ev_s5.kind == m2fr_pkg::KIND_FLOW) begin
					quality_q <= ev_s5.quality;
					flow_x_q  <= conv_x;
					flow_y_q  <= conv_y;
				end else begin
					range_q <= ev_s5.range;
				end
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign update_kind  = kind_q;
	assign flow_quality = quality_q;
	assign flow_x_rad   = flow_x_q;
	assign flow_y_rad   = flow_y_q;
	assign range_mm     = range_q;

endmodule

`default_nettype wire

[rtl/m2fr_checker.sv]
`default_nettype none

module m2fr_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_ready,
	input wire logic [7:0]                      rx_byte,
	input wire logic                            out_valid,
	input wire logic                            out_ready,
	input wire logic                            update_kind,
	input wire logic [7:0]                      flow_quality,
	input wire logic signed [31:0]              flow_x_rad,
	input wire logic signed [31:0]              flow_y_rad,
	input wire logic signed [31:0]              range_mm,
	input wire logic                            cfg_valid,
	input wire logic                            cfg_ready
);

	// A waiting input byte stays put until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(rx_byte))
		else $error("input byte changed while waiting");

	// A stalled result holds its values
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(update_kind) &&
		$stable(flow_quality) && $stable(flow_x_rad) && $stable(flow_y_rad) &&
		$stable(range_mm))
		else $error("result changed while stalled");

	// A result leaves only through a completed transaction
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without transaction");

	// Input backs up only when the output is stalled
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	// Register writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind msp2_flow_range_frame_parser m2fr_checker u_m2fr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.rx_byte      (rx_byte),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.update_kind  (update_kind),
	.flow_quality (flow_quality),
	.flow_x_rad   (flow_x_rad),
	.flow_y_rad   (flow_y_rad),
	.range_mm     (range_mm),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

`default_nettype wire

[verif/msp2_flow_range_frame_parser_tb.sv]
`default_nettype none

module msp2_flow_range_frame_parser_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASES       = 6;
	localparam int BYTES_PER_PH = 325;

	typedef logic [7:0] octets_t[$];
	typedef logic [m2fr_pkg::CFG_IDX_W-1:0] cfg_idx_t;

	// One update as seen on the result channel
	typedef struct {
		logic        kind;
		logic [7:0]  quality;
		logic [31:0] flow_x;
		logic [31:0] flow_y;
		logic [31:0] range;
	} update_t;

	// Scoreboard: tracks the parser and the latest values, queues expected updates
	class update_board;
		logic [15:0]       flow_id;
		logic [15:0]       range_id;
		m2fr_pkg::phase_t  phase;
		logic [15:0]       pos;
		logic [15:0]       fid;
		logic [15:0]       flen;
		logic [7:0]        payload [m2fr_pkg::KEEP_BYTES];
		logic [7:0]        last_quality;
		logic [31:0]       last_x;
		logic [31:0]       last_y;
		logic [31:0]       last_range;
		update_t           pending_updates[$];
		int                errors;
		int                flow_updates;
		int                range_updates;

		function new();
			flow_id = m2fr_pkg::FLOW_ID_RST;
			range_id = m2fr_pkg::RANGE_ID_RST;
			phase = m2fr_pkg::PH_HUNT;
			pos = '0;
			fid = '0;
			flen = '0;
			foreach (payload[i]) payload[i] = '0;
			last_quality = '0;
			last_x = '0;
			last_y = '0;
			last_range = '0;
			errors = 0;
			flow_updates = 0;
			range_updates = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [15:0] val);
			if (idx == m2fr_pkg::REG_FLOW_ID)
				flow_id = val;
			else if (idx == m2fr_pkg::REG_RANGE_ID)
				range_id = val;
		endfunction

		function logic [31:0] le32(int start);
			return {payload[start+3], payload[start+2], payload[start+1], payload[start]};
		endfunction

		// Tenths of deg/s to Q16.16 rad/s: round(|r| * 44680448 / 390625), signed, saturated
		function logic [31:0] deg_tenths_to_q16(logic [31:0] raw);
			logic [31:0]     neg_raw;
			longint unsigned mag;
			longint unsigned q;
			neg_raw = ~raw + 32'd1;
			mag = raw[31] ? 64'(neg_raw) : 64'(raw);
			q = (mag * 64'd44680448 + 64'd195312) / 64'd390625;
			if (!raw[31])
				return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
			if (q >= 64'h8000_0000)
				return 32'h8000_0000;
			return 32'd0 - q[31:0];
		endfunction

		// Advance the parser by one accepted byte
		function void take_byte(logic [7:0] b);
			update_t u;
			bit      fire;
			fire = 0;
			case (phase)
				m2fr_pkg::PH_GOT_SOF: begin
					if (b == m2fr_pkg::VER_CHAR) begin
						phase = m2fr_pkg::PH_HEADER;
						pos = '0;
						fid = '0;
						flen = '0;
					end else if (b != m2fr_pkg::SOF_CHAR) begin
						phase = m2fr_pkg::PH_HUNT;
					end
				end
				m2fr_pkg::PH_HEADER: begin
					case (pos)
						m2fr_pkg::POS_ID_LO:  fid[7:0] = b;
						m2fr_pkg::POS_ID_HI:  fid[15:8] = b;
						m2fr_pkg::POS_LEN_LO: flen[7:0] = b;
						m2fr_pkg::POS_LEN_HI: flen[15:8] = b;
						default: ;
					endcase
					if (pos >= m2fr_pkg::POS_LEN_HI) begin
						pos = '0;
						phase = (flen == 16'd0) ? m2fr_pkg::PH_CHECK : m2fr_pkg::PH_PAYLOAD;
					end else begin
						pos = pos + 16'd1;
					end
				end
				m2fr_pkg::PH_PAYLOAD: begin
					if (pos < m2fr_pkg::KEEP_LIMIT)
						payload[pos] = b;
					pos = pos + 16'd1;
					if (pos >= flen) begin
						pos = '0;
						phase = m2fr_pkg::PH_CHECK;
					end
				end
				m2fr_pkg::PH_CHECK: begin
					// flow test wins when both ids match
					if (fid == flow_id && flen >= m2fr_pkg::FLOW_MIN_LEN) begin
						last_quality = payload[0];
						last_x = deg_tenths_to_q16(le32(1));
						last_y = deg_tenths_to_q16(le32(5));
						u.kind = m2fr_pkg::KIND_FLOW;
						fire = 1;
						flow_updates++;
					end else if (fid == range_id && flen >= m2fr_pkg::RANGE_MIN_LEN) begin
						last_range = le32(1);
						u.kind = m2fr_pkg::KIND_RANGE;
						fire = 1;
						range_updates++;
					end
					phase = m2fr_pkg::PH_HUNT;
					pos = '0;
				end
				default: phase = (b == m2fr_pkg::SOF_CHAR) ? m2fr_pkg::PH_GOT_SOF
				                                          : m2fr_pkg::PH_HUNT;
			endcase
			if (fire) begin
				u.quality = last_quality;
				u.flow_x = last_x;
				u.flow_y = last_y;
				u.range = last_range;
				pending_updates.push_back(u);
			end
		endfunction

		function void check_result(update_t got);
			update_t exp;
			if (pending_updates.size() == 0) begin
				$error("update received with none pending");
				errors++;
				return;
			end
			exp = pending_updates.pop_front();
			if (got.kind !== exp.kind) begin
				$error("update_kind expected %0h got %0h", exp.kind, got.kind);
				errors++;
			end
			if (got.quality !== exp.quality) begin
				$error("flow_quality expected %0h got %0h", exp.quality, got.quality);
				errors++;
			end
			if (got.flow_x !== exp.flow_x) begin
				$error("flow_x_rad expected %0h got %0h", exp.flow_x, got.flow_x);
				errors++;
			end
			if (got.flow_y !== exp.flow_y) begin
				$error("flow_y_rad expected %0h got %0h", exp.flow_y, got.flow_y);
				errors++;
			end
			if (got.range !== exp.range) begin
				$error("range_mm expected %0h got %0h", exp.range, got.range);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic                 update_kind;
	logic [7:0]           flow_quality;
	logic signed [31:0]   flow_x_rad;
	logic signed [31:0]   flow_y_rad;
	logic signed [31:0]   range_mm;
	logic                 cfg_valid;
	logic                 cfg_ready;
	cfg_idx_t             cfg_index;
	logic [15:0]          cfg_data;

	update_board sb;
	update_t     seen;
	logic [7:0]  tx_q[$];
	bit          no_idle;
	int          ready_left;
	int          cycles;
	int          sent;

	msp2_flow_range_frame_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.update_kind  (update_kind),
		.flow_quality (flow_quality),
		.flow_x_rad   (flow_x_rad),
		.flow_y_rad   (flow_y_rad),
		.range_mm     (range_mm),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Idle length: mostly short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	// Raw flow value: small, mid, near the saturation knee, extremes, or anything
	function automatic logic [31:0] rand_raw();
		logic [31:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1: v = $urandom_range(0, 2000);
			2: v = $urandom_range(18700000, 18850000);
			3: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'hFFFF_FFFF;
					default: v = 32'h0;
				endcase
			end
			default: v = $urandom_range(0, 32'h00FF_FFFF);
		endcase
		if ($urandom_range(0, 1) == 1)
			v = 32'd0 - v;
		return v;
	endfunction

	function automatic octets_t with_word(octets_t q, logic [31:0] v);
		for (int i = 0; i < 4; i++)
			q.push_back(v[8*i +: 8]);
		return q;
	endfunction

	function automatic octets_t pad(octets_t q, int n);
		repeat (n) q.push_back(8'($urandom));
		return q;
	endfunction

	function automatic octets_t flow_body(logic [7:0] qual, logic [31:0] rx, logic [31:0] ry,
			int extra);
		octets_t q;
		q.push_back(qual);
		q = with_word(q, rx);
		q = with_word(q, ry);
		return pad(q, extra);
	endfunction

	function automatic octets_t range_body(logic [31:0] d, int extra);
		octets_t q;
		q.push_back(8'($urandom));
		q = with_word(q, d);
		return pad(q, extra);
	endfunction

	function automatic octets_t rand_body(int n);
		octets_t q;
		return pad(q, n);
	endfunction

	// Header, random flag and direction, id, length, body, unchecked checksum
	function automatic void push_frame(logic [15:0] id, octets_t body);
		logic [15:0] len;
		len = 16'(body.size());
		tx_q.push_back(m2fr_pkg::SOF_CHAR);
		tx_q.push_back(m2fr_pkg::VER_CHAR);
		tx_q.push_back(8'($urandom));
		tx_q.push_back(8'($urandom));
		tx_q.push_back(id[7:0]);
		tx_q.push_back(id[15:8]);
		tx_q.push_back(len[7:0]);
		tx_q.push_back(len[15:8]);
		foreach (body[i]) tx_q.push_back(body[i]);
		tx_q.push_back(8'($urandom));
	endfunction

	// One random stimulus item: mostly valid frames, some noise and broken headers
	function automatic void gen_item();
		int         r;
		int         n;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			tx_q.push_back(m2fr_pkg::SOF_CHAR);
		if (r < 40) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
			push_frame(sb.flow_id, flow_body(8'($urandom), rand_raw(), rand_raw(), n));
		end else if (r < 68) begin
			push_frame(sb.range_id, range_body(rand_raw(), $urandom_range(0, 5)));
		end else if (r < 78) begin
			n = ($urandom_range(0, 4) == 0) ? 40 : 12;
			push_frame(16'($urandom), rand_body($urandom_range(0, n)));
		end else if (r < 86) begin
			// matching id with a short body
			push_frame(($urandom_range(0, 1) == 1) ? sb.flow_id : sb.range_id,
				rand_body($urandom_range(0, 8)));
		end else if (r < 94) begin
			// noise never carries the second header byte
			n = $urandom_range(1, 6);
			repeat (n) begin
				b = 8'($urandom);
				if (b == m2fr_pkg::VER_CHAR)
					b = ~b;
				tx_q.push_back(b);
			end
		end else begin
			b = 8'($urandom);
			if (b == m2fr_pkg::VER_CHAR)
				b = m2fr_pkg::SOF_CHAR;
			tx_q.push_back(m2fr_pkg::SOF_CHAR);
			tx_q.push_back(b);
		end
	endfunction

	// Push out queued bytes, one transaction each
	task automatic send_all();
		int gap;
		while (tx_q.size() > 0) begin
			in_valid <= 1'b1;
			rx_byte <= tx_q[0];
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			sb.take_byte(tx_q.pop_front());
			sent++;
			gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Wait until all updates are out and the pipeline has drained
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_updates.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: check each accepted update, randomize out_ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen.kind = update_kind;
			seen.quality = flow_quality;
			seen.flow_x = flow_x_rad;
			seen.flow_y = flow_y_rad;
			seen.range = range_mm;
			sb.check_result(seen);
		end
		if (ready_left > 0) begin
			ready_left--;
		end else if (no_idle || $urandom_range(0, 2) != 0) begin
			out_ready <= 1'b1;
			ready_left = $urandom_range(0, 6);
		end else begin
			out_ready <= 1'b0;
			ready_left = idle_len() - 1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("msp2_flow_range_frame_parser verification failed");
			$finish;
		end
	end

	initial begin
		octets_t     nothing;
		logic [15:0] v;
		sb = new();
		no_idle = 0;
		ready_left = 0;
		cycles = 0;
		sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		rx_byte <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					// reset ids; stray bytes, broken and repeated start bytes
					tx_q.push_back(8'h00);
					tx_q.push_back(8'hFF);
					tx_q.push_back(m2fr_pkg::VER_CHAR);
					tx_q.push_back(m2fr_pkg::SOF_CHAR);
					tx_q.push_back(8'h41);
					tx_q.push_back(m2fr_pkg::SOF_CHAR);
					tx_q.push_back(m2fr_pkg::SOF_CHAR);
					tx_q.push_back(m2fr_pkg::SOF_CHAR);
					push_frame(sb.flow_id, flow_body(8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 0));
					push_frame(sb.flow_id, flow_body(8'h00, 32'hFFFF_FFFF, 32'h0000_0001, 0));
					push_frame(sb.flow_id, flow_body(8'h5A, 32'd10, 32'hFFFF_FFF6, 0));
					push_frame(sb.range_id, range_body(32'h8000_0000, 0));
					// body past the kept bytes
					push_frame(sb.range_id, range_body(32'h7FFF_FFFF, 7));
					// zero length, then bodies one short of the minimum
					push_frame(sb.flow_id, nothing);
					push_frame(sb.flow_id, rand_body(8));
					push_frame(sb.range_id, rand_body(4));
					// header bytes inside a body are plain data
					push_frame(sb.range_id ^ 16'h5555,
						with_word(nothing, {m2fr_pkg::VER_CHAR, m2fr_pkg::SOF_CHAR,
							m2fr_pkg::VER_CHAR, m2fr_pkg::SOF_CHAR}));
					push_frame(16'($urandom), rand_body(272));
					send_all();
				end
				1: begin
					// both ids equal: mid length reads as range, full length as flow
					v = 16'($urandom);
					set_reg(m2fr_pkg::REG_FLOW_ID, v);
					set_reg(m2fr_pkg::REG_RANGE_ID, v);
					push_frame(v, range_body(rand_raw(), 2));
					push_frame(v, flow_body(8'($urandom), rand_raw(), rand_raw(), 0));
					send_all();
				end
				2: begin
					set_reg(m2fr_pkg::REG_FLOW_ID, 16'h0000);
					set_reg(m2fr_pkg::REG_RANGE_ID, 16'hFFFF);
				end
				3: begin
					set_reg(m2fr_pkg::REG_FLOW_ID, 16'hFFFF);
					set_reg(m2fr_pkg::REG_RANGE_ID, 16'h0000);
				end
				4: begin
					set_reg(m2fr_pkg::REG_FLOW_ID, 16'($urandom));
					set_reg(m2fr_pkg::REG_RANGE_ID, 16'($urandom));
					// writes past the register map are dropped
					set_reg(m2fr_pkg::REG_RANGE_ID + cfg_idx_t'(1), 16'($urandom));
					set_reg(m2fr_pkg::REG_RANGE_ID + cfg_idx_t'($urandom_range(2, 14)),
						16'($urandom));
				end
				default: begin
					set_reg(m2fr_pkg::REG_FLOW_ID, m2fr_pkg::FLOW_ID_RST);
					set_reg(m2fr_pkg::REG_RANGE_ID, m2fr_pkg::RANGE_ID_RST);
					no_idle = 1;
				end
			endcase
			begin
				int target;
				// byte budget is shared across phases, directed bytes included
				target = (ph + 1) * BYTES_PER_PH;
				while (sent < target) begin
					gen_item();
					send_all();
				end
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d bytes over %0d id settings: %0d flow and %0d range updates checked",
			sent, PHASES, sb.flow_updates, sb.range_updates);
		if (sb.errors == 0)
			$display("msp2_flow_range_frame_parser verification clean");
		else
			$display("msp2_flow_range_frame_parser verification failed");
		$finish;
	end

endmodule

`default_nettype wire
